[hw/rtl/smh_pkg.sv]
// ----------------------------------------------------------------------------
// smh_pkg: shared types and constants
// Item formats, queue entry and split 64-bit multiply helpers for the stack
// trace hash block.
// ----------------------------------------------------------------------------
package smh_pkg;

  localparam logic [63:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT     = 47;
  localparam logic [63:0] SEED_AT_RESET = 64'h000000FAFAFAFAFA;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [63:0] frame_address;
    logic [5:0]  frame_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        hash_value;
    logic signed [31:0] trace_id;
  } out_item_t;

  // scrambled word plus what the back end needs to fold it in
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] seed_init;
    logic        first;
    logic        last;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // partial products of a * MIX_MUL, mod 2^64
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] cross_a;
    logic [31:0] cross_b;
  } pp_t;

  function automatic pp_t mul_m_pp(input logic [63:0] a);
    pp_t p;
    p.lo      = 64'(a[31:0]) * 64'(MIX_MUL[31:0]);
    p.cross_a = a[31:0] * MIX_MUL[63:32];
    p.cross_b = a[63:32] * MIX_MUL[31:0];
    return p;
  endfunction

  function automatic logic [63:0] mul_m_sum(input pp_t p);
    logic [31:0] mid_sum;
    mid_sum = p.cross_a + p.cross_b;
    return p.lo + {mid_sum, 32'b0};
  endfunction

endpackage

[hw/rtl/smh_front.sv]
// ----------------------------------------------------------------------------
// smh_front: item intake and key scramble
// Accepts words, marks stack start/end, computes the seed for a first word
// and scrambles the key through a four-stage stallable pipeline.
// ----------------------------------------------------------------------------
module smh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smh_pkg::in_item_t in_item,
  input  logic [63:0]       seed,
  output logic              push_valid,
  input  logic              push_ready,
  output smh_pkg::q_entry_t push_entry
);
  import smh_pkg::*;

  logic        in_stack_r, in_stack_nxt;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        r1, r2, r3, r4;
  pp_t         pp1_r, pp3_r;
  logic [63:0] k2_r, k4_r;
  logic [63:0] seed1_r, seed2_r, seed3_r, seed4_r;
  logic [3:0]  first_r, last_r;
  logic [63:0] k1;
  logic        accept;

  assign r4       = !v4_r || push_ready;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;
  assign accept   = in_valid && in_ready;

  assign in_stack_nxt = accept ? !in_item.last_word : in_stack_r;

  // first multiply resolved, then xorshift
  assign k1 = mul_m_sum(pp1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_stack_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
    end else begin
      in_stack_r <= in_stack_nxt;
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      pp1_r      <= mul_m_pp(in_item.frame_address);
      seed1_r    <= seed ^ (64'(in_item.frame_count) * MIX_MUL);
      first_r[0] <= !in_stack_r;
      last_r[0]  <= in_item.last_word;
    end
    if (r2) begin
      k2_r       <= k1 ^ (k1 >> MIX_SHIFT);
      seed2_r    <= seed1_r;
      first_r[1] <= first_r[0];
      last_r[1]  <= last_r[0];
    end
    if (r3) begin
      pp3_r      <= mul_m_pp(k2_r);
      seed3_r    <= seed2_r;
      first_r[2] <= first_r[1];
      last_r[2]  <= last_r[1];
    end
    if (r4) begin
      k4_r       <= mul_m_sum(pp3_r);
      seed4_r    <= seed3_r;
      first_r[3] <= first_r[2];
      last_r[3]  <= last_r[2];
    end
  end

  assign push_valid           = v4_r;
  assign push_entry.key       = k4_r;
  assign push_entry.seed_init = seed4_r;
  assign push_entry.first     = first_r[3];
  assign push_entry.last      = last_r[3];

endmodule

[hw/rtl/smh_queue.sv]
// ----------------------------------------------------------------------------
// smh_queue: short register queue
// Decouples the scramble pipeline from the hash loop.
// ----------------------------------------------------------------------------
module smh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  smh_pkg::q_entry_t  push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output smh_pkg::q_entry_t  pop_entry,
  output smh_pkg::q_status_t status
);
  import smh_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  assign status.full  = !push_ready;
  assign status.empty = !pop_valid;
  assign status.count = cnt_r;

endmodule

[hw/rtl/smh_back.sv]
// ----------------------------------------------------------------------------
// smh_back: running hash loop
// Folds each scrambled key into the running hash with a split multiply
// and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module smh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  smh_pkg::q_entry_t  pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output smh_pkg::out_item_t out_item
);
  import smh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SUM
  } state_t;

  state_t      state_r;
  logic [63:0] hash_r;
  pp_t         pp_r;
  logic        last_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic [63:0] base;
  logic [63:0] h_new;
  logic        do_pop;

  // pop only when the output slot is free by the time the sum lands
  assign pop_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign do_pop    = pop_valid && pop_ready;
  assign base      = pop_entry.first ? pop_entry.seed_init : hash_r;
  assign h_new     = mul_m_sum(pp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
      hash_r      <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (do_pop) state_r <= ST_SUM;
        end
        ST_SUM: begin
          state_r <= ST_IDLE;
          if (last_r) begin
            out_valid_r           <= 1'b1;
            out_item_r.hash_value <= h_new;
            out_item_r.trace_id   <= signed'(h_new[31:0]);
            hash_r                <= '0;
          end else begin
            hash_r <= h_new;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      pp_r   <= mul_m_pp(base ^ pop_entry.key);
      last_r <= pop_entry.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[hw/rtl/stack_trace_murmur_hash_top.sv]
// ----------------------------------------------------------------------------
// stack_trace_murmur_hash_top: stack trace hash unit
// Hashes a stream of 64-bit frame words into one 64-bit hash per stack.
// ----------------------------------------------------------------------------
//  channel | ports                          | carries
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_item  | frame word, count, last flag
//  result  | out_valid / out_ready/out_item | hash and signed trace id
//  config  | cfg_we / cfg_wdata             | hash seed
//
// Sustained intake is set by the dependent split multiply in the hash
// loop, which pops no new word until the last sum is done. With the loop
// idle, out_valid rises once the last word clears scramble, queue and sum.
// The 4-stage key scramble and the 2-entry queue run ahead of the loop.
// Reset clears all control state; the seed returns to 0xFAFAFAFAFA.
// A stalled result register holds; intake keeps going until the queue and scramble fill.
// ----------------------------------------------------------------------------
module stack_trace_murmur_hash_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  smh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output smh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata
);
  import smh_pkg::*;

  logic      [63:0] seed_r;
  logic             push_valid, push_ready;
  q_entry_t         push_entry;
  logic             pop_valid, pop_ready;
  q_entry_t         pop_entry;
  q_status_t        q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_AT_RESET;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  smh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .seed       (seed_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  smh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .status     (q_stat)
  );

  smh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_id_matches_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.trace_id == signed'(out_item.hash_value[31:0])))
    else $error("trace_id does not match low hash bits");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && (q_stat.count <= QCNT_W'(QUEUE_DEPTH)))
    else $error("queue status inconsistent");

  a_pop_waits_output: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready && out_valid) |-> out_ready)
    else $error("word popped while result register blocked");

endmodule

[tb/sv/stack_hash_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_hash_checker: result scoreboard for the stack trace hash unit
// Watches the input, result and seed ports, keeps its own running hash per
// stack trace and compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module stack_hash_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  smh_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  smh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  output int                 mismatches,
  output int                 hashes_owed
);
  import smh_pkg::*;

  logic [63:0] seed_model;
  logic [63:0] partial_hash;
  logic        in_trace;
  out_item_t   hash_fifo[$];

  function automatic logic [63:0] scramble_key(input logic [63:0] k);
    logic [63:0] t;
    t = k * MIX_MUL;
    t = t ^ (t >> MIX_SHIFT);
    return t * MIX_MUL;
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] h;
    out_item_t   want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      seed_model   = SEED_AT_RESET;
      partial_hash = '0;
      in_trace     = 1'b0;
      hash_fifo.delete();
      mismatches  <= 0;
      hashes_owed <= 0;
    end else begin
      // result side first: an item accepted this edge cannot be out yet
      if (out_valid && out_ready) begin
        if (hash_fifo.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual hash %h id %h",
                   $time, out_item.hash_value, out_item.trace_id);
          errs++;
        end else begin
          want = hash_fifo.pop_front();
          if (out_item.hash_value !== want.hash_value) begin
            $display("%0t: hash_value mismatch: expected %h, actual %h",
                     $time, want.hash_value, out_item.hash_value);
            errs++;
          end
          if (out_item.trace_id !== want.trace_id) begin
            $display("%0t: trace_id mismatch: expected %h, actual %h",
                     $time, want.trace_id, out_item.trace_id);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        // count only seeds the first word of a trace
        h = in_trace ? partial_hash
                     : seed_model ^ (64'(in_item.frame_count) * MIX_MUL);
        h = (h ^ scramble_key(in_item.frame_address)) * MIX_MUL;
        if (in_item.last_word) begin
          want.hash_value = h;
          want.trace_id   = h[31:0];
          hash_fifo.push_back(want);
          partial_hash = '0;
          in_trace     = 1'b0;
        end else begin
          partial_hash = h;
          in_trace     = 1'b1;
        end
      end
      // new seed takes effect from the next first word
      if (cfg_we) seed_model = cfg_wdata;
      mismatches  <= mismatches + errs;
      hashes_owed <= hash_fifo.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stack trace hash unit
// Drives stack traces of frame words with random gaps and result back
// pressure, changes the seed between phases and leaves checking to the
// scoreboard instance beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import smh_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int RUN_LIMIT_NS = 3_000_000;
  localparam int SLOTS        = 60;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [63:0] cfg_wdata = '0;

  int mismatches;
  int hashes_owed;
  bit gaps_on  = 1'b0;
  bit hold_req = 1'b0;

  stack_trace_murmur_hash_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stack_hash_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .hashes_owed (hashes_owed)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    bit hold_served;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic push_word(input logic [63:0] addr, input logic [5:0] count,
                           input logic last);
    in_item_t w;
    w.frame_address = addr;
    w.frame_count   = count;
    w.last_word     = last;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // words past the frame count are zero when padded; count on later words is noise
  task automatic send_stack(input int words, input logic [5:0] count, input bit pad_zero);
    logic [63:0] a;
    logic [5:0]  c;
    for (int i = 0; i < words; i++) begin
      a = {$urandom, $urandom};
      if (pad_zero && i >= count) a = '0;
      c = (i == 0) ? count : 6'($urandom);
      push_word(a, c, i == words - 1);
    end
  endtask

  task automatic random_stacks(input int budget, input bit short_only);
    int          left;
    int          words;
    int          pick;
    logic [5:0]  count;
    left = budget;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      if (short_only) words = $urandom_range(1, 3);
      else if (pick == 0) words = SLOTS;
      else if (pick < 3) words = $urandom_range(1, 70);
      else words = $urandom_range(1, 8);
      count = 6'($urandom_range(0, (words < SLOTS) ? words : SLOTS));
      if (pick == 19) count = 6'($urandom_range(SLOTS + 1, 63));
      send_stack(words, count, pick < 16);
      left -= words;
    end
  endtask

  // wait for every result, then let the pipeline empty out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset seed; single-word traces at the field extremes, then multi-word traces
    push_word(64'h0, 6'd0, 1'b1);
    push_word('1, 6'd63, 1'b1);
    send_stack(3, 6'd2, 1'b1);
    push_word(64'h8000_0000_0000_0001, 6'd60, 1'b0);
    push_word('1, 6'd17, 1'b0);
    push_word(64'h1, 6'd0, 1'b1);
    push_word(64'hFFFF_FFFF_0000_0000, 6'd61, 1'b1);

    // seed rewritten in the middle of a trace
    push_word(64'h0123_4567_89AB_CDEF, 6'd5, 1'b0);
    drain();
    write_seed('1);
    push_word(64'hFEDC_BA98_7654_3210, 6'd0, 1'b1);
    push_word(64'h0, 6'd1, 1'b1);

    drain();
    write_seed(64'h0);
    push_word('1, 6'd60, 1'b1);
    send_stack(4, 6'd3, 1'b1);

    drain();
    write_seed(SEED_AT_RESET);
    gaps_on <= 1'b1;
    random_stacks(250, 1'b0);

    // long result stall while short traces keep coming
    drain();
    write_seed({$urandom, $urandom});
    hold_req <= 1'b1;
    random_stacks(40, 1'b1);
    random_stacks(210, 1'b0);

    drain();
    write_seed({$urandom, $urandom});
    random_stacks(350, 1'b0);

    drain();
    write_seed(64'h1);
    gaps_on <= 1'b0;
    random_stacks(250, 1'b0);

    drain();
    if (mismatches == 0 && hashes_owed == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
